// File: rtl/six_button_pad_select_mux_defines.svh
// Assertion macros used by the checker file of the pad select mux.
`ifndef SIX_BUTTON_PAD_SELECT_MUX_DEFINES_SVH
`define SIX_BUTTON_PAD_SELECT_MUX_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sbp_pkg.sv
// Types and constants of the six-button pad select mux.
package sbp_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned WordSelW   = 3;
  localparam int unsigned EdgeCntW   = 4;
  localparam int unsigned NowW       = 48;
  localparam int unsigned WindowW    = 24;
  localparam int unsigned ButtonsW   = 26;
  localparam int unsigned FlagsW     = 8;
  localparam int unsigned PortW      = 8;
  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned ApbDataW   = 32;

  typedef logic [PortW-1:0]    pad_word_t;
  typedef logic [WordSelW-1:0] word_sel_t;
  typedef logic [EdgeCntW-1:0] edge_cnt_t;

  // Item kinds
  localparam logic FUNC_BUTTONS = 1'b0;
  localparam logic FUNC_FLAGS   = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_ENABLE     = 2'd0;
  localparam logic [1:0] REG_PORT_INDEX = 2'd1;
  localparam logic [1:0] REG_WINDOW     = 2'd2;

  localparam logic [WindowW-1:0] WINDOW_RESET = 24'd12000;

  // Pad word bit masks
  localparam logic [3:0] DIR_MASK    = 4'hf;
  localparam pad_word_t  LOW_FORCE   = 8'h0c;
  localparam pad_word_t  LOW_NIBBLE  = 8'h0f;
  localparam pad_word_t  HIGH_NIBBLE = 8'hf0;

  // Word indexes walked by the select sequence
  localparam word_sel_t WSEL_BASE  = 3'd0;
  localparam word_sel_t WSEL_HIGH  = 3'd1;
  localparam word_sel_t WSEL_ALLUP = 3'd2;
  localparam word_sel_t WSEL_EXT   = 3'd3;
  localparam word_sel_t WSEL_ALLDN = 3'd4;

  // Sequence counts
  localparam edge_cnt_t EDGE_MAX       = 4'd15;
  localparam edge_cnt_t EDGE_HIGH_WRAP = 4'd7;
  localparam edge_cnt_t EDGE_HIGH_EXT  = 4'd5;
  localparam edge_cnt_t EDGE_LOW_ALLDN = 4'd6;
  localparam edge_cnt_t EDGE_LOW_ALLUP = 4'd4;

endpackage

// File: rtl/sbp_if.sv
// Request channel interfaces of the pad select mux.
interface sbp_in_if;
  import sbp_pkg::*;
  logic                valid;
  logic                ready;
  logic                func;
  logic [ButtonsW-1:0] buttons;
  logic [FlagsW-1:0]   flags;
  logic [NowW-1:0]     now;

  modport source (output valid, func, buttons, flags, now, input ready);
  modport sink   (input valid, func, buttons, flags, now, output ready);
endinterface

interface sbp_out_if;
  import sbp_pkg::*;
  logic             valid;
  logic             ready;
  logic [PortW-1:0] port_value;

  modport source (output valid, port_value, input ready);
  modport sink   (input valid, port_value, output ready);
endinterface

// File: rtl/six_button_pad_select_mux.sv
// Six-button pad select mux: packs button words and walks the select sequence.
// A request passes the input register, then the result register; one request per cycle
// is accepted while the result side does not stall.
// The pad word and sequence state update in the cycle a request leaves the input register.
// Reset (rst_ni low, asynchronous) clears pad words, sequence state and valids,
// and loads the registers with enable=1, port_index=0, window_cycles=12000.
module six_button_pad_select_mux
  import sbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sbp_in_if.sink              in_i,
  sbp_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  // Configuration registers
  logic               enable_q;
  logic               port_index_q;
  logic [WindowW-1:0] window_cycles_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q        <= 1'b1;
      port_index_q    <= 1'b0;
      window_cycles_q <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_ENABLE:     enable_q        <= pwdata[0];
        REG_PORT_INDEX: port_index_q    <= pwdata[0];
        REG_WINDOW:     window_cycles_q <= pwdata[WindowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:     prdata = {{(ApbDataW-1){1'b0}}, enable_q};
      REG_PORT_INDEX: prdata = {{(ApbDataW-1){1'b0}}, port_index_q};
      REG_WINDOW:     prdata = {{(ApbDataW-WindowW){1'b0}}, window_cycles_q};
      default:        prdata = '0;
    endcase
  end

  // Input register
  logic                s1_valid_q;
  logic                s1_func_q;
  logic [ButtonsW-1:0] s1_buttons_q;
  logic [FlagsW-1:0]   s1_flags_q;
  logic [NowW-1:0]     s1_now_q;
  logic                out_valid_q;
  pad_word_t           out_value_q;
  logic                advance;
  logic                in_accept;

  assign advance   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q    <= in_i.func;
      s1_buttons_q <= in_i.buttons;
      s1_flags_q   <= in_i.flags;
      s1_now_q     <= in_i.now;
    end
  end

  // Pad state
  pad_word_t           pad_words_q [NumWords];
  pad_word_t           pad_words_d [NumWords];
  word_sel_t           word_select_q, word_select_d;
  edge_cnt_t           edge_count_q, edge_count_d;
  logic [NowW-1:0]     window_start_q, window_start_d;

  logic [3:0]  dirs;
  pad_word_t   w0;
  logic        sel_line;
  logic        in_window;
  logic [NowW:0] window_end;
  edge_cnt_t   bumped;
  word_sel_t   read_sel;

  assign dirs       = s1_buttons_q[3:0] & DIR_MASK;
  assign w0         = {1'b0, s1_buttons_q[25], s1_buttons_q[16], 1'b0, dirs} | LOW_FORCE;
  assign sel_line   = port_index_q ? s1_flags_q[5] : s1_flags_q[4];
  assign window_end = {1'b0, window_start_q} + {{(NowW+1-WindowW){1'b0}}, window_cycles_q};
  assign in_window  = {1'b0, s1_now_q} < window_end;
  assign bumped     = (edge_count_q == EDGE_MAX) ? EDGE_MAX : edge_count_q + 4'd1;

  always_comb begin
    pad_words_d    = pad_words_q;
    word_select_d  = word_select_q;
    edge_count_d   = edge_count_q;
    window_start_d = window_start_q;
    if (s1_func_q == FUNC_BUTTONS) begin
      if (!enable_q) begin
        pad_words_d[0] = '0;
        pad_words_d[1] = '0;
        pad_words_d[3] = '0;
      end else begin
        pad_words_d[0] = w0;
        pad_words_d[1] = {1'b0, s1_buttons_q[18], s1_buttons_q[17], 1'b0, dirs};
        pad_words_d[2] = w0 | LOW_NIBBLE;
        pad_words_d[3] = {1'b0, s1_buttons_q[21], s1_buttons_q[20], 1'b0,
                          s1_buttons_q[19], s1_buttons_q[24], 2'b00};
        pad_words_d[4] = w0 & HIGH_NIBBLE;
      end
    end else if (sel_line) begin
      word_select_d = WSEL_HIGH;
      if (in_window) begin
        edge_count_d = bumped;
        if (bumped == EDGE_HIGH_WRAP) begin
          edge_count_d = '0;
        end else if (bumped == EDGE_HIGH_EXT) begin
          word_select_d = WSEL_EXT;
        end
      end else begin
        edge_count_d = '0;
      end
    end else begin
      word_select_d = WSEL_BASE;
      if (in_window) begin
        edge_count_d = bumped;
        if (bumped == EDGE_LOW_ALLDN) begin
          word_select_d = WSEL_ALLDN;
        end else if (bumped == EDGE_LOW_ALLUP) begin
          word_select_d  = WSEL_ALLUP;
          window_start_d = s1_now_q;
        end
      end else begin
        edge_count_d   = '0;
        window_start_d = s1_now_q;
      end
    end
  end

  assign read_sel = (word_select_d > WSEL_ALLDN) ? WSEL_BASE : word_select_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) begin
        pad_words_q[i] <= '0;
      end
      word_select_q  <= WSEL_BASE;
      edge_count_q   <= '0;
      window_start_q <= '0;
    end else if (advance) begin
      pad_words_q    <= pad_words_d;
      word_select_q  <= word_select_d;
      edge_count_q   <= edge_count_d;
      window_start_q <= window_start_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_value_q <= ~pad_words_d[read_sel];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.port_value = out_value_q;

endmodule

// File: rtl/sbp_checker.sv
// Port-level checks of the pad select mux and their bind.
`include "six_button_pad_select_mux_defines.svh"

module sbp_checker
  import sbp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PortW-1:0] port_value_i,
  input logic             pready_i
);

  `SBP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(port_value_i), "result dropped or changed while stalled")

  // Pad words never drive bit 7, so the inverted port shows it high.
  `SBP_ASSERT_NOW(a_bit7_high, out_valid_i, port_value_i[PortW-1], "port bit 7 low")

  // A request accepted in the previous cycle reaches the result register unless blocked.
  `SBP_ASSERT_NEXT(a_advance, $past(in_valid_i && in_ready_i) && (!out_valid_i || out_ready_i), out_valid_i, "accepted request did not reach the result")

  `SBP_ASSERT_NOW(a_pready, 1'b1, pready_i, "pready low")

endmodule

bind six_button_pad_select_mux sbp_checker u_sbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .port_value_i (out_o.port_value),
  .pready_i     (pready)
);

// File: sim/tb_top.sv
// Testbench of the pad select mux: a directed table, then random requests checked by a predictor.
`timescale 1ns / 100ps

module tb_top;
  import sbp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseReqs  = 221;
  localparam int unsigned MaxPrinted = 40;

  typedef struct packed {
    logic                func;
    logic [ButtonsW-1:0] buttons;
    logic [FlagsW-1:0]   flags;
    logic [NowW-1:0]     now;
  } pad_req_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic                func;
    logic [ButtonsW-1:0] buttons;
    logic [FlagsW-1:0]   flags;
    logic [NowW-1:0]     now;
    logic [1:0]          reg_idx;
    logic [ApbDataW-1:0] reg_val;
    logic                typed;
    pad_word_t           port_exp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  sbp_in_if  req_ch ();
  sbp_out_if res_ch ();

  six_button_pad_select_mux dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted register and pad state
  logic               cfg_enable = 1'b1;
  logic               cfg_port   = 1'b0;
  logic [WindowW-1:0] cfg_window = WINDOW_RESET;
  pad_word_t          pad_words [NumWords] = '{default: '0};
  word_sel_t          word_sel   = WSEL_BASE;
  edge_cnt_t          edge_cnt   = '0;
  logic [NowW-1:0]    win_start  = '0;

  pad_word_t   port_values_due [$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned burst_left = 0;
  int unsigned rx_hold_req = 0;

  dir_row_t dir_rows [32] = '{
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h00, 48'd0,    REG_ENABLE, 32'h0, 1'b1, 8'hff},
    '{ROW_REQ, FUNC_BUTTONS, 26'h0,       8'h00, 48'd0,    REG_ENABLE, 32'h0, 1'b1, 8'hf3},
    '{ROW_REQ, FUNC_BUTTONS, 26'h3ffffff, 8'h00, 48'd0,    REG_ENABLE, 32'h0, 1'b1, 8'h90},
    // count up through the six-button walk
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h10, 48'd100,  REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'hef, 48'd200,  REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h00, 48'd300,  REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h10, 48'd400,  REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h00, 48'd500,  REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h00, 48'd600,  REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'hff, 48'd700,  REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h00, 48'd800,  REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h10, 48'd900,  REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h00, 48'd1000, REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h10, 48'd1100, REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h00, 48'd1200, REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h10, 48'd1300, REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h00, 48'd1400, REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h10, 48'd1500, REG_ENABLE, 32'h0, 1'b0, 8'h00},
    // time going backwards, then the largest stamp
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h10, 48'd5,    REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h00, 48'hffffffffffff,
      REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_CFG, FUNC_BUTTONS, 26'h0, 8'h00, 48'd0, REG_ENABLE,     32'h0,        1'b0, 8'h00},
    '{ROW_CFG, FUNC_BUTTONS, 26'h0, 8'h00, 48'd0, REG_PORT_INDEX, 32'h1,        1'b0, 8'h00},
    '{ROW_CFG, FUNC_BUTTONS, 26'h0, 8'h00, 48'd0, REG_WINDOW,     32'h00ffffff, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_BUTTONS, 26'h3ffffff, 8'h00, 48'd0,    REG_ENABLE, 32'h0, 1'b1, 8'hff},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h20, 48'd1,    REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'hdf, 48'd2,    REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_CFG, FUNC_BUTTONS, 26'h0, 8'h00, 48'd0, REG_ENABLE,     32'h1,        1'b0, 8'h00},
    '{ROW_CFG, FUNC_BUTTONS, 26'h0, 8'h00, 48'd0, REG_PORT_INDEX, 32'h0,        1'b0, 8'h00},
    '{ROW_CFG, FUNC_BUTTONS, 26'h0, 8'h00, 48'd0, REG_WINDOW,     32'h0,        1'b0, 8'h00},
    // zero window: nothing counts
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h10, 48'd0,    REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_FLAGS,   26'h0,       8'h00, 48'd0,    REG_ENABLE, 32'h0, 1'b0, 8'h00},
    '{ROW_REQ, FUNC_BUTTONS, 26'h1555555, 8'h00, 48'd0,    REG_ENABLE, 32'h0, 1'b0, 8'h00}
  };

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    if (mismatches < MaxPrinted) $display("tb_top: mismatch: %s at %0t", what, $realtime);
    mismatches++;
  endtask

  // Apply one request to the pad state; return the port value it drives.
  function automatic pad_word_t pad_port_after(input pad_req_t r);
    pad_word_t w0;
    logic      sel_line;
    logic      in_window;
    if (r.func == FUNC_BUTTONS) begin
      if (!cfg_enable) begin
        pad_words[0] = '0;
        pad_words[1] = '0;
        pad_words[3] = '0;
      end else begin
        w0 = {1'b0, r.buttons[25], r.buttons[16], 1'b0, r.buttons[3:0]} | LOW_FORCE;
        pad_words[0] = w0;
        pad_words[1] = {1'b0, r.buttons[18], r.buttons[17], 1'b0, r.buttons[3:0]};
        pad_words[2] = w0 | LOW_NIBBLE;
        pad_words[3] = {1'b0, r.buttons[21], r.buttons[20], 1'b0, r.buttons[19],
                        r.buttons[24], 2'b00};
        pad_words[4] = w0 & HIGH_NIBBLE;
      end
    end else begin
      sel_line  = r.flags[4 + int'(cfg_port)];
      in_window = {1'b0, r.now} < ({1'b0, win_start} + (NowW+1)'(cfg_window));
      if (in_window && edge_cnt < EDGE_MAX) edge_cnt = edge_cnt + 1'b1;
      if (sel_line) begin
        word_sel = WSEL_HIGH;
        if (!in_window) begin
          edge_cnt = '0;
        end else if (edge_cnt == EDGE_HIGH_WRAP) begin
          edge_cnt = '0;
        end else if (edge_cnt == EDGE_HIGH_EXT) begin
          word_sel = WSEL_EXT;
        end
      end else begin
        word_sel = WSEL_BASE;
        if (!in_window) begin
          edge_cnt  = '0;
          win_start = r.now;
        end else if (edge_cnt == EDGE_LOW_ALLDN) begin
          word_sel = WSEL_ALLDN;
        end else if (edge_cnt == EDGE_LOW_ALLUP) begin
          word_sel  = WSEL_ALLUP;
          win_start = r.now;
        end
      end
    end
    return ~pad_words[(int'(word_sel) < NumWords) ? int'(word_sel) : 0];
  endfunction

  // Offer one request in bursts with gaps; record its port value once accepted.
  task automatic push_request(input pad_req_t r, input logic typed, input pad_word_t typed_val);
    pad_word_t port_exp;
    if (burst_left == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    req_ch.valid   = 1'b1;
    req_ch.func    = r.func;
    req_ch.buttons = r.buttons;
    req_ch.flags   = r.flags;
    req_ch.now     = r.now;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    port_exp = pad_port_after(r);
    port_values_due.push_back(typed ? typed_val : port_exp);
  endtask

  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (port_values_due.size() != 0) @(negedge clk_i);
  endtask

  // Read a register and compare with the predicted value; ends at a falling edge.
  task automatic read_check(input logic [1:0] idx);
    logic [ApbDataW-1:0] want;
    logic [ApbDataW-1:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    case (idx)
      REG_ENABLE:     want = ApbDataW'(cfg_enable);
      REG_PORT_INDEX: want = ApbDataW'(cfg_port);
      REG_WINDOW:     want = ApbDataW'(cfg_window);
      default:        want = '0;
    endcase
    if (got !== want)
      report_mismatch($sformatf("register %0d read %08h want %08h", idx, got, want));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ApbDataW-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_ENABLE:     cfg_enable = val[0];
      REG_PORT_INDEX: cfg_port   = val[0];
      REG_WINDOW:     cfg_window = val[WindowW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    read_check(idx);
  endtask

  // Result side: stall on a changing duty, or hold off when asked.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned duty;
    hold_left = 0;
    mode_left = 0;
    duty      = 100;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(8, 80);
          case ($urandom_range(0, 3))
            0:       duty = 100;
            1:       duty = 70;
            2:       duty = 40;
            default: duty = 15;
          endcase
        end
        mode_left--;
        res_ch.ready = ($urandom_range(1, 100) <= duty);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (port_values_due.size() == 0) begin
        report_mismatch($sformatf("unexpected port_value %02h", res_ch.port_value));
      end else if (res_ch.port_value !== port_values_due[0]) begin
        report_mismatch($sformatf("port_value %02h want %02h",
                                  res_ch.port_value, port_values_due[0]));
        void'(port_values_due.pop_front());
      end else begin
        void'(port_values_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    pad_req_t        r;
    logic [NowW-1:0] stamp;
    int unsigned     sent_here;
    int unsigned     seq_len;
    int unsigned     span;
    logic            alt;
    logic [ApbDataW-1:0] win_val;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_ch.valid   = 1'b0;
    req_ch.func    = FUNC_BUTTONS;
    req_ch.buttons = '0;
    req_ch.flags   = '0;
    req_ch.now     = '0;
    stamp          = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    read_check(REG_ENABLE);
    read_check(REG_PORT_INDEX);
    read_check(REG_WINDOW);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        push_request({dir_rows[i].func, dir_rows[i].buttons, dir_rows[i].flags,
                      dir_rows[i].now}, dir_rows[i].typed, dir_rows[i].port_exp);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0:       win_val = 32'd1;
        1:       win_val = 32'h00ffffff;
        default: begin
          case ($urandom_range(0, 3))
            0:       win_val = ApbDataW'($urandom_range(1, 64));
            1:       win_val = ApbDataW'($urandom_range(65, 20000));
            2:       win_val = ApbDataW'(WINDOW_RESET);
            default: win_val = ApbDataW'($urandom_range(1, 32'h00ffffff));
          endcase
        end
      endcase
      write_reg(REG_ENABLE, (ph == 2) ? 32'd0 : ApbDataW'($urandom_range(0, 3) != 0));
      write_reg(REG_PORT_INDEX, ApbDataW'($urandom_range(0, 1)));
      write_reg(REG_WINDOW, win_val);
      // block fills and stalls its input while results are held off
      if (ph == 1) rx_hold_req = 300;
      sent_here = 0;
      while (sent_here < PhaseReqs) begin
        if ($urandom_range(0, 9) < 7) begin
          seq_len = $urandom_range(2, 18);
          alt     = ($urandom_range(0, 9) < 7);
          span    = cfg_window / 6;
          if (span == 0) span = 1;
          // start past the window so the first low write opens a fresh one
          stamp = stamp + NowW'(cfg_window) + NowW'($urandom_range(0, 40));
          for (int k = 0; k < seq_len; k++) begin
            if (k > 0 && $urandom_range(0, 4) == 0) begin
              r.func    = FUNC_BUTTONS;
              r.buttons = ButtonsW'($urandom);
              r.flags   = FlagsW'($urandom);
              r.now     = NowW'({$urandom, $urandom});
            end else begin
              r.func    = FUNC_FLAGS;
              r.buttons = ButtonsW'($urandom);
              r.flags   = FlagsW'($urandom);
              r.flags[4 + int'(cfg_port)] = (k == 0) ? 1'b0 :
                                            alt ? k[0] : 1'($urandom_range(0, 1));
              case ($urandom_range(0, 19))
                0: begin
                  stamp = stamp + NowW'(cfg_window) + 1'b1;
                  r.now = stamp;
                end
                1:       r.now = stamp - NowW'($urandom_range(1, 1000));
                default: begin
                  stamp = stamp + NowW'($urandom_range(0, span));
                  r.now = stamp;
                end
              endcase
            end
            push_request(r, 1'b0, '0);
            sent_here++;
          end
        end else begin
          r.func    = 1'($urandom_range(0, 1));
          r.buttons = ButtonsW'($urandom);
          r.flags   = FlagsW'($urandom);
          r.now     = NowW'({$urandom, $urandom});
          push_request(r, 1'b0, '0);
          sent_here++;
        end
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
